[design/krh_pkg.sv]
// Shared types, constants and helpers for the Karp-Rabin hash combine block.
// Used by every module of the block; depends on nothing else.
package krh_pkg;

	localparam int MODULUS_EXPONENT = 61;
	localparam int HASH_WIDTH       = MODULUS_EXPONENT;
	localparam int LENGTH_BITS_DEF  = 32;
	localparam int HALF_WIDTH       = 32;
	localparam int HIGH_WIDTH       = MODULUS_EXPONENT - HALF_WIDTH;
	localparam int PROD_WIDTH       = 2 * MODULUS_EXPONENT;

	typedef logic [MODULUS_EXPONENT-1:0] residue_t;

	localparam residue_t PRIME   = '1;
	localparam residue_t ONE_RES = residue_t'(1);

	// Map the one non-canonical value (p itself) to zero.
	function automatic residue_t canon(input residue_t v);
		return (v == PRIME) ? '0 : v;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOP,
		ST_ACCM,
		ST_PWAIT,
		ST_FWAIT,
		ST_COMB
	} state_t;

	// Operand select for the modular multiplier; also tags its writeback.
	typedef enum logic [1:0] {
		MS_SQUARE,
		MS_ACC,
		MS_FINAL
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     issue;
		mul_sel_t sel;
		logic     shift;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_lsb;
		logic mul_busy;
	} dp_sts_t;

endpackage

[design/krh_mulmod.sv]
// Pipelined multiplier modulo 2^61-1: four partial products, sum, two folds.
// Depends on krh_pkg.
module krh_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue,
	input  krh_pkg::mul_sel_t issue_tag,
	input  krh_pkg::residue_t x,
	input  krh_pkg::residue_t y,
	output logic              prod_valid,
	output krh_pkg::mul_sel_t prod_tag,
	output krh_pkg::residue_t prod_value,
	output logic              busy
);
	import krh_pkg::*;

	logic     v_s1, v_s2, v_s3, v_s4;
	mul_sel_t tag_s1, tag_s2, tag_s3, tag_s4;
	residue_t x_s1, y_s1;

	logic [2*HALF_WIDTH-1:0]         pp00_s2;
	logic [HALF_WIDTH+HIGH_WIDTH-1:0] pp01_s2, pp10_s2;
	logic [2*HIGH_WIDTH-1:0]         pp11_s2;
	logic [PROD_WIDTH-1:0]           prod_s3;
	logic [MODULUS_EXPONENT:0]       fold_s4;

	logic [2*HALF_WIDTH-1:0]         pp00;
	logic [HALF_WIDTH+HIGH_WIDTH-1:0] pp01, pp10;
	logic [2*HIGH_WIDTH-1:0]         pp11;
	logic [PROD_WIDTH-1:0]           prod_sum;
	logic [MODULUS_EXPONENT:0]       fold_sum;
	residue_t                        fold_last;

	// 32x32-class partial products
	assign pp00 = (2*HALF_WIDTH)'(x_s1[HALF_WIDTH-1:0]) *
		(2*HALF_WIDTH)'(y_s1[HALF_WIDTH-1:0]);
	assign pp01 = (HALF_WIDTH+HIGH_WIDTH)'(x_s1[HALF_WIDTH-1:0]) *
		(HALF_WIDTH+HIGH_WIDTH)'(y_s1[MODULUS_EXPONENT-1:HALF_WIDTH]);
	assign pp10 = (HALF_WIDTH+HIGH_WIDTH)'(x_s1[MODULUS_EXPONENT-1:HALF_WIDTH]) *
		(HALF_WIDTH+HIGH_WIDTH)'(y_s1[HALF_WIDTH-1:0]);
	assign pp11 = (2*HIGH_WIDTH)'(x_s1[MODULUS_EXPONENT-1:HALF_WIDTH]) *
		(2*HIGH_WIDTH)'(y_s1[MODULUS_EXPONENT-1:HALF_WIDTH]);

	assign prod_sum = PROD_WIDTH'(pp00_s2)
		+ (PROD_WIDTH'(pp01_s2) << HALF_WIDTH)
		+ (PROD_WIDTH'(pp10_s2) << HALF_WIDTH)
		+ (PROD_WIDTH'(pp11_s2) << (2*HALF_WIDTH));

	assign fold_sum = {1'b0, prod_s3[MODULUS_EXPONENT-1:0]}
		+ (MODULUS_EXPONENT+1)'(prod_s3[PROD_WIDTH-1:MODULUS_EXPONENT]);

	// second fold cannot overflow: the top case lands exactly on p
	assign fold_last = fold_s4[MODULUS_EXPONENT-1:0] + residue_t'(fold_s4[MODULUS_EXPONENT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		y_s1    <= y;
		tag_s1  <= issue_tag;
		pp00_s2 <= pp00;
		pp01_s2 <= pp01;
		pp10_s2 <= pp10;
		pp11_s2 <= pp11;
		tag_s2  <= tag_s1;
		prod_s3 <= prod_sum;
		tag_s3  <= tag_s2;
		fold_s4 <= fold_sum;
		tag_s4  <= tag_s3;
	end

	assign prod_valid = v_s4;
	assign prod_tag   = tag_s4;
	assign prod_value = canon(fold_last);
	assign busy       = v_s1 | v_s2 | v_s3 | v_s4;

`ifndef NO_ASSERTIONS
	a_out_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		prod_valid |-> (prod_value != PRIME))
		else $error("multiplier result not reduced below p");
`endif

endmodule

[design/krh_datapath.sv]
// Datapath: operand registers, exponent shifter, multiplier, final combine.
// Depends on krh_pkg and krh_mulmod.
module krh_datapath #(
	parameter int LENGTH_BITS = krh_pkg::LENGTH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  krh_pkg::dp_cmd_t            cmd,
	output krh_pkg::dp_sts_t            sts,
	input  logic                        cfg_we,
	input  logic [krh_pkg::HASH_WIDTH-1:0] cfg_data,
	input  logic                        operation,
	input  logic [krh_pkg::HASH_WIDTH-1:0] first_hash,
	input  logic [krh_pkg::HASH_WIDTH-1:0] second_hash,
	input  logic [LENGTH_BITS-1:0]      suffix_length,
	output logic                        done,
	output logic [krh_pkg::HASH_WIDTH-1:0] hash_out
);
	import krh_pkg::*;

	residue_t             base_q;
	logic                 op_q;
	residue_t             first_q, second_q;
	logic [LENGTH_BITS-1:0] exp_q;
	residue_t             acc_q, sq_q, prod_q;
	residue_t             hash_out_q;
	logic                 done_q;

	residue_t             mul_x, mul_y;
	logic                 mul_out_valid;
	mul_sel_t             mul_out_tag;
	residue_t             mul_out_value;
	logic                 mul_busy;

	logic [MODULUS_EXPONENT:0] cat_sum;
	logic [MODULUS_EXPONENT:0] sub_diff;
	residue_t             cat_res, sub_res;

	always_comb begin
		case (cmd.sel)
			MS_SQUARE: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
			MS_ACC: begin
				mul_x = acc_q;
				mul_y = sq_q;
			end
			MS_FINAL: begin
				mul_x = op_q ? second_q : first_q;
				mul_y = acc_q;
			end
			default: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
		endcase
	end

	krh_mulmod u_mulmod (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (cmd.issue),
		.issue_tag  (cmd.sel),
		.x          (mul_x),
		.y          (mul_y),
		.prod_valid (mul_out_valid),
		.prod_tag   (mul_out_tag),
		.prod_value (mul_out_value),
		.busy       (mul_busy)
	);

	// concat: fold (t + second); subtract: first - t, adding p on borrow
	assign cat_sum  = {1'b0, prod_q} + {1'b0, second_q};
	assign cat_res  = canon(cat_sum[MODULUS_EXPONENT-1:0] + residue_t'(cat_sum[MODULUS_EXPONENT]));
	assign sub_diff = {1'b0, first_q} - {1'b0, prod_q};
	assign sub_res  = sub_diff[MODULUS_EXPONENT] ?
		(sub_diff[MODULUS_EXPONENT-1:0] - ONE_RES) : sub_diff[MODULUS_EXPONENT-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			first_q  <= canon(first_hash);
			second_q <= canon(second_hash);
		end
		if (cmd.load) begin
			exp_q <= suffix_length;
		end else if (cmd.shift) begin
			exp_q <= exp_q >> 1;
		end
		if (cmd.load) begin
			acc_q <= ONE_RES;
			sq_q  <= canon(base_q);
		end else if (mul_out_valid) begin
			case (mul_out_tag)
				MS_SQUARE: sq_q   <= mul_out_value;
				MS_ACC:    acc_q  <= mul_out_value;
				MS_FINAL:  prod_q <= mul_out_value;
				default: ;
			endcase
		end
		if (cmd.finish) begin
			hash_out_q <= op_q ? sub_res : cat_res;
		end
	end

	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_lsb  = exp_q[0];
	assign sts.mul_busy = mul_busy;
	assign done         = done_q;
	assign hash_out     = hash_out_q;

`ifndef NO_ASSERTIONS
	a_result_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hash_out != PRIME))
		else $error("combined hash not reduced below p");
`endif

endmodule

[design/krh_ctrl.sv]
// Sequencer for square-and-multiply and the final combine step.
// Depends on krh_pkg.
module krh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  krh_pkg::dp_sts_t sts,
	output krh_pkg::dp_cmd_t cmd,
	output logic             busy
);
	import krh_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_next = ST_LOOP;
			end
			ST_LOOP: begin
				if (sts.exp_zero) state_next = ST_FWAIT;
				else if (sts.exp_lsb) state_next = ST_ACCM;
				else state_next = ST_PWAIT;
			end
			ST_ACCM:  state_next = ST_PWAIT;
			ST_PWAIT: begin
				if (!sts.mul_busy) state_next = ST_LOOP;
			end
			ST_FWAIT: begin
				if (!sts.mul_busy) state_next = ST_COMB;
			end
			ST_COMB:  state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{load: 1'b0, issue: 1'b0, sel: MS_SQUARE, shift: 1'b0, finish: 1'b0};
		unique case (state_q)
			ST_IDLE: cmd.load = start;
			ST_LOOP: begin
				cmd.issue = 1'b1;
				if (sts.exp_zero) begin
					cmd.sel = MS_FINAL;
				end else begin
					cmd.sel   = MS_SQUARE;
					cmd.shift = 1'b1;
				end
			end
			ST_ACCM: begin
				cmd.issue = 1'b1;
				cmd.sel   = MS_ACC;
			end
			ST_COMB: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
	a_loop_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> !sts.mul_busy)
		else $error("issue while multiplier still holds results");
	a_accm_after_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCM) |-> $past(state_q == ST_LOOP))
		else $error("accumulate step not paired with a square");
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !sts.mul_busy)
		else $error("multiplier active while idle");
`endif

endmodule

[design/karp_rabin_hash_combine_core.sv]
// Top level of the Karp-Rabin hash combine block (modulus 2^61-1).
// Depends on krh_pkg, krh_ctrl, krh_datapath (and krh_mulmod below it).
// The 4-stage modular multiplier is waited out once per exponent bit.
// One item at a time; start is taken again in the cycle done pulses. Reset clears base to 0.
module karp_rabin_hash_combine_core #(
	parameter int LENGTH_BITS = krh_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item command channel
	input  logic                           start,
	output logic                           busy,
	input  logic                           operation,
	input  logic [krh_pkg::HASH_WIDTH-1:0] first_hash,
	input  logic [krh_pkg::HASH_WIDTH-1:0] second_hash,
	input  logic [LENGTH_BITS-1:0]         suffix_length,
	// base register write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [krh_pkg::HASH_WIDTH-1:0] cfg_data,
	// result: valid for one cycle while done is high, no backpressure
	output logic                           done,
	output logic [krh_pkg::HASH_WIDTH-1:0] hash_out
);
	import krh_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    ctrl_busy;

	// The sequencer walks the exponent LSB first: each step squares the running
	// base power and, for a set bit, multiplies it into the accumulator. Both
	// products go through the shared pipelined multiplier back to back, then the
	// sequencer waits for the pipe to drain before the next bit.
	krh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	// Datapath holds the operands, base register, exponent and the combine
	// logic; the final multiply gives first*B^L (concat) or second*B^L (subtract).
	krh_datapath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.first_hash    (first_hash),
		.second_hash   (second_hash),
		.suffix_length (suffix_length),
		.done          (done),
		.hash_out      (hash_out)
	);

	assign busy = ctrl_busy;
	// base only changes between items, never at the edge an item is taken
	assign cfg_ready = !ctrl_busy & !start;

endmodule
